FILE: rtl/core/pwm_pkg.sv
// Shared types and constants for the period weighted mean unit.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package pwm_pkg;

  // Field widths of one transaction.
  localparam int ACTION_W = 2;
  localparam int PRICE_W  = 32;
  localparam int VOL_W    = 16;
  localparam int IDX_W    = 6;

  // Accumulator and product widths.
  localparam int PROD_W = PRICE_W + VOL_W;
  localparam int SUM_W  = 64;
  localparam int WT_W   = 32;

  // History ring geometry.
  localparam int HISTORY_DEPTH = 64;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = HIST_AW + 1;

  // Command queue between the front and back ends.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Serial divider: one quotient bit per cycle.
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef logic [ACTION_W-1:0] action_t;

  localparam action_t ACT_TICK   = 2'd0;
  localparam action_t ACT_CLOSE  = 2'd1;
  localparam action_t ACT_READ   = 2'd2;
  localparam action_t ACT_UNUSED = 2'd3;

  // One classified command as it travels through the queue.
  typedef struct packed {
    action_t              action;
    logic [PRICE_W-1:0]   price;
    logic [PROD_W-1:0]    product;
    logic [VOL_W-1:0]     volume;
    logic [IDX_W-1:0]     index;
  } pwm_item_t;

endpackage

FILE: rtl/core/period_weighted_mean_unit.sv
// Period weighted mean unit: ticks are taken one per cycle while the queue has room and pass
// through the front register and the queue into the accumulators. A bar close runs a serial
// divide before raising its result; a zero-weight close skips it, and a history read uses the ring.
// Closes and reads hold the back end, so their throughput is set by the divider, ring and result handshake.
// Synchronous reset clears the accumulators, queue and pointers; ring contents stay undefined.
`timescale 1ns / 1ps

module period_weighted_mean_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  pwm_pkg::action_t           action,
  input  logic [pwm_pkg::PRICE_W-1:0] price,
  input  logic [pwm_pkg::VOL_W-1:0]  volume,
  input  logic [pwm_pkg::IDX_W-1:0]  history_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pwm_pkg::PRICE_W-1:0] bar_mean,
  output logic                       used_close,
  output logic                       entry_valid
);
  import pwm_pkg::*;

  pwm_item_t f_item;
  logic      f_valid;
  logic      f_ready;
  pwm_item_t q_item;
  logic      q_valid;
  logic      q_ready;

  // Front end: acceptance, classification and the tick product.
  pwm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .price         (price),
    .volume        (volume),
    .history_index (history_index),
    .item_valid    (f_valid),
    .item_ready    (f_ready),
    .item          (f_item)
  );

  // Queue between the two halves.
  pwm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Back end: accumulation, division, history and results.
  pwm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bar_mean    (bar_mean),
    .used_close  (used_close),
    .entry_valid (entry_valid)
  );

endmodule

FILE: rtl/core/pwm_front.sv
// Front end: accepts input transactions, drops unused action codes and
// forms the tick product. Depends on pwm_pkg.
`timescale 1ns / 1ps

module pwm_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  pwm_pkg::action_t           action,
  input  logic [pwm_pkg::PRICE_W-1:0] price,
  input  logic [pwm_pkg::VOL_W-1:0]  volume,
  input  logic [pwm_pkg::IDX_W-1:0]  history_index,
  output logic                       item_valid,
  input  logic                       item_ready,
  output pwm_pkg::pwm_item_t         item
);
  import pwm_pkg::*;

  logic f_valid;

  // The stage is free when empty or when its content moves on this cycle.
  assign in_ready   = !f_valid || item_ready;
  assign item_valid = f_valid;

  // Control: an unused action code is accepted and then forgotten.
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid && (action != ACT_UNUSED);
    end
  end

  // Payload with the registered price times volume product.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.action  <= action;
      item.price   <= price;
      item.product <= PROD_W'(price) * PROD_W'(volume);
      item.volume  <= volume;
      item.index   <= history_index;
    end
  end

endmodule

FILE: rtl/core/pwm_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on pwm_pkg for the item type and depth.
`timescale 1ns / 1ps

module pwm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  pwm_pkg::pwm_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output pwm_pkg::pwm_item_t pop_item
);
  import pwm_pkg::*;

  pwm_item_t             entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: rtl/core/pwm_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on pwm_pkg for operand widths and the step count.
`timescale 1ns / 1ps

module pwm_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [pwm_pkg::SUM_W-1:0] dividend,
  input  logic [pwm_pkg::WT_W-1:0] divisor,
  output logic                     done,
  output logic [pwm_pkg::SUM_W-1:0] quotient
);
  import pwm_pkg::*;

  logic              busy;
  logic [DIV_CW-1:0] step;
  logic [WT_W-1:0]   rem;
  logic [WT_W-1:0]   dvs;
  logic [WT_W:0]     shifted;
  logic              fits;

  // Bring down the next dividend bit and try the subtraction.
  assign shifted = {rem, quotient[SUM_W-1]};
  assign fits    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      // Done pulses for one cycle after the last quotient bit.
      done <= !start && busy && (step == DIV_CW'(DIV_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == DIV_CW'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath; the quotient shifts in where the dividend shifts out.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[SUM_W-2:0], fits};
      rem      <= fits ? WT_W'(shifted - {1'b0, dvs}) : shifted[WT_W-1:0];
    end
  end

endmodule

FILE: rtl/core/pwm_back.sv
// Back end: accumulates ticks, closes bars, weighted ones through the serial divider,
// keeps the history ring and drives the result register. Depends on pwm_pkg, pwm_div.
`timescale 1ns / 1ps

module pwm_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  pwm_pkg::pwm_item_t         q_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pwm_pkg::PRICE_W-1:0] bar_mean,
  output logic                       used_close,
  output logic                       entry_valid
);
  import pwm_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_READ, B_OUT} state_t;

  state_t               state;
  logic [SUM_W-1:0]     weighted_sum;
  logic [WT_W-1:0]      weight_total;
  logic [HIST_AW-1:0]   write_slot;
  logic [CNT_W-1:0]     filled_count;
  logic [PRICE_W-1:0]   ring [HISTORY_DEPTH];
  logic [PRICE_W-1:0]   rd_data;
  logic                 rd_hit_r;
  logic [PRICE_W-1:0]   res_mean;
  logic                 res_used;
  logic                 res_entry;
  logic                 res_close;

  logic                 pop;
  logic                 out_load;
  logic                 div_start;
  logic                 div_done;
  logic [SUM_W-1:0]     div_quo;
  logic [SUM_W:0]       sum_ext;
  logic [SUM_W-1:0]     sum_next;
  logic [WT_W:0]        wt_ext;
  logic [WT_W-1:0]      wt_next;
  logic                 rd_hit;
  logic [CNT_W-1:0]     back_sum;
  logic [CNT_W-1:0]     back_wrap;
  logic [HIST_AW-1:0]   back_addr;
  logic [HIST_AW-1:0]   slot_next;
  logic [PRICE_W-1:0]   quo_sat;

  // Commands are taken only while no close or read is in flight.
  assign q_ready   = (state == B_IDLE);
  assign pop       = q_ready && q_valid;
  assign out_load  = (state == B_OUT) && (!out_valid || out_ready);
  assign div_start = pop && (q_item.action == ACT_CLOSE) && (weight_total != '0);

  // Saturating accumulator updates.
  assign sum_ext  = {1'b0, weighted_sum} + (SUM_W+1)'(q_item.product);
  assign sum_next = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign wt_ext   = {1'b0, weight_total} + (WT_W+1)'(q_item.volume);
  assign wt_next  = wt_ext[WT_W] ? '1 : wt_ext[WT_W-1:0];

  // Reverse index to ring slot, wrapping once around the ring.
  assign rd_hit    = (CNT_W'(q_item.index) < filled_count);
  assign back_sum  = CNT_W'(write_slot) + CNT_W'(HISTORY_DEPTH - 1) - CNT_W'(q_item.index);
  assign back_wrap = (back_sum >= CNT_W'(HISTORY_DEPTH)) ?
                     (back_sum - CNT_W'(HISTORY_DEPTH)) : back_sum;
  assign back_addr = back_wrap[HIST_AW-1:0];

  assign slot_next = (write_slot == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : write_slot + 1'b1;

  // A quotient beyond 32 bits only follows saturation; clamp it.
  assign quo_sat = (div_quo[SUM_W-1:PRICE_W] != '0) ? '1 : div_quo[PRICE_W-1:0];

  pwm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (weighted_sum),
    .divisor  (weight_total),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer, accumulators, history pointers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      weighted_sum <= '0;
      weight_total <= '0;
      write_slot   <= '0;
      filled_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop) begin
            case (q_item.action)
              ACT_TICK: begin
                weighted_sum <= sum_next;
                weight_total <= wt_next;
              end
              ACT_CLOSE: begin
                if (weight_total == '0) begin
                  res_mean  <= q_item.price;
                  res_used  <= 1'b1;
                  res_entry <= 1'b1;
                  res_close <= 1'b1;
                  state     <= B_OUT;
                end else begin
                  state <= B_DIV;
                end
              end
              ACT_READ: begin
                rd_hit_r <= rd_hit;
                state    <= B_READ;
              end
              default: begin
              end
            endcase
          end
        end
        B_DIV: begin
          if (div_done) begin
            res_mean  <= quo_sat;
            res_used  <= 1'b0;
            res_entry <= 1'b1;
            res_close <= 1'b1;
            state     <= B_OUT;
          end
        end
        B_READ: begin
          res_mean  <= rd_hit_r ? rd_data : '0;
          res_used  <= 1'b0;
          res_entry <= rd_hit_r;
          res_close <= 1'b0;
          state     <= B_OUT;
        end
        B_OUT: begin
          if (out_load) begin
            out_valid   <= 1'b1;
            bar_mean    <= res_mean;
            used_close  <= res_used;
            entry_valid <= res_entry;
            if (res_close) begin
              write_slot   <= slot_next;
              weighted_sum <= '0;
              weight_total <= '0;
              if (filled_count < CNT_W'(HISTORY_DEPTH)) begin
                filled_count <= filled_count + 1'b1;
              end
            end
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // History ring: written when a closed bar's transaction is issued.
  always_ff @(posedge clk) begin
    if (out_load && res_close) begin
      ring[write_slot] <= res_mean;
    end
  end

  // Registered ring read for history requests.
  always_ff @(posedge clk) begin
    if (pop && (q_item.action == ACT_READ)) begin
      rd_data <= ring[back_addr];
    end
  end

  // The filled count never passes the ring depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    filled_count <= CNT_W'(HISTORY_DEPTH))
    else $error("filled count beyond history depth");

  // A substituted close price always comes with a valid entry.
  a_used_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && used_close |-> entry_valid)
    else $error("used_close without entry_valid");

  // The divider finishes only while the sequencer waits for it.
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == B_DIV)
    else $error("divider result with no close pending");

  // Closing a bar leaves both accumulators cleared.
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    out_load && res_close |=> weighted_sum == '0 && weight_total == '0)
    else $error("accumulators not cleared after close");

endmodule

FILE: bench/pwm_bar_checker.sv
// Checker for the period weighted mean unit: watches both channels, predicts each result
// and compares it field by field. Depends on pwm_pkg for field widths and action codes.
`timescale 1ns / 1ps

module pwm_bar_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  pwm_pkg::action_t            action,
  input  logic [pwm_pkg::PRICE_W-1:0] price,
  input  logic [pwm_pkg::VOL_W-1:0]   volume,
  input  logic [pwm_pkg::IDX_W-1:0]   history_index,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [pwm_pkg::PRICE_W-1:0] bar_mean,
  input  logic                        used_close,
  input  logic                        entry_valid,
  output int                          mismatch_count,
  output int                          results_pending
);
  import pwm_pkg::*;

  typedef struct {
    logic [PRICE_W-1:0] mean;
    logic               used_close;
    logic               entry_valid;
  } bar_report_t;

  // Predicted bar state: running sums, mean history and its pointers.
  logic [SUM_W-1:0]   acc_sum;
  logic [WT_W-1:0]    acc_weight;
  logic [PRICE_W-1:0] mean_history [HISTORY_DEPTH];
  logic [HIST_AW-1:0] next_slot;
  logic [CNT_W-1:0]   bars_held;

  bar_report_t expected_reports[$];

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
  end

  // Advances the predicted state by one accepted transaction and queues any result it gives.
  task automatic apply_command(input action_t act, input logic [PRICE_W-1:0] p,
                               input logic [VOL_W-1:0] v, input logic [IDX_W-1:0] idx);
    logic [SUM_W-1:0] product;
    logic [SUM_W:0]   sum_next;
    logic [WT_W:0]    weight_next;
    logic [SUM_W-1:0] quotient;
    bar_report_t      rep;
    int               back;
    case (act)
      ACT_TICK: begin
        // Both sums clamp at all ones instead of wrapping.
        product     = p * v;
        sum_next    = acc_sum + product;
        weight_next = acc_weight + v;
        acc_sum     = sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
        acc_weight  = weight_next[WT_W] ? '1 : weight_next[WT_W-1:0];
      end
      ACT_CLOSE: begin
        // A bar with no weight reports the supplied close price.
        if (acc_weight == '0) begin
          rep.mean       = p;
          rep.used_close = 1'b1;
        end else begin
          quotient       = acc_sum / acc_weight;
          rep.mean       = (|quotient[SUM_W-1:PRICE_W]) ? '1 : quotient[PRICE_W-1:0];
          rep.used_close = 1'b0;
        end
        rep.entry_valid         = 1'b1;
        mean_history[next_slot] = rep.mean;
        next_slot  = (next_slot == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : next_slot + 1'b1;
        if (bars_held < HISTORY_DEPTH) begin
          bars_held = bars_held + 1'b1;
        end
        acc_sum    = '0;
        acc_weight = '0;
        expected_reports.push_back(rep);
      end
      ACT_READ: begin
        // Index 0 is the newest bar; entries past the filled count read as invalid.
        if (idx < bars_held) begin
          back            = (int'(next_slot) + HISTORY_DEPTH - 1 - int'(idx)) % HISTORY_DEPTH;
          rep.mean        = mean_history[back];
          rep.entry_valid = 1'b1;
        end else begin
          rep.mean        = '0;
          rep.entry_valid = 1'b0;
        end
        rep.used_close = 1'b0;
        expected_reports.push_back(rep);
      end
      default: begin
        // The spare action code leaves everything untouched.
      end
    endcase
  endtask

  task automatic compare_field(input string field, input logic [PRICE_W-1:0] want,
                               input logic [PRICE_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  // Matches one result transaction against the oldest prediction.
  task automatic check_report();
    bar_report_t want;
    if (expected_reports.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result, expected none, actual %h %b %b",
               $time, bar_mean, used_close, entry_valid);
    end else begin
      want = expected_reports.pop_front();
      compare_field("bar_mean", want.mean, bar_mean);
      compare_field("used_close", PRICE_W'(want.used_close), PRICE_W'(used_close));
      compare_field("entry_valid", PRICE_W'(want.entry_valid), PRICE_W'(entry_valid));
    end
  endtask

  // Both channels are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      acc_sum    = '0;
      acc_weight = '0;
      next_slot  = '0;
      bars_held  = '0;
      expected_reports.delete();
    end else begin
      if (in_valid && in_ready) begin
        apply_command(action, price, volume, history_index);
      end
      if (out_valid && out_ready) begin
        check_report();
      end
    end
    results_pending = expected_reports.size();
  end

endmodule

FILE: bench/period_weighted_mean_unit_test.sv
// Top of the period weighted mean unit bench: clock, reset, stimulus, output flow control
// and the verdict. Depends on pwm_pkg, period_weighted_mean_unit and pwm_bar_checker.
`timescale 1ns / 1ps

module period_weighted_mean_unit_test;
  import pwm_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int FULL_TICKS   = 8;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_BURST   = 60;
  localparam int LONG_HOLD    = 400;
  localparam int PARK_AT      = 1000;
  localparam int QUIET_AFTER  = 1450;
  localparam int DRAIN_CYCLES = 150;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  action_t              action        = ACT_TICK;
  logic [PRICE_W-1:0]   price         = '0;
  logic [VOL_W-1:0]     volume        = '0;
  logic [IDX_W-1:0]     history_index = '0;
  logic                 out_valid;
  logic                 out_ready     = 1'b0;
  logic [PRICE_W-1:0]   bar_mean;
  logic                 used_close;
  logic                 entry_valid;

  int mismatch_count;
  int results_pending;

  bit idling_on     = 1'b1;
  bit hold_output   = 1'b0;
  bit hold_served   = 1'b0;
  int gap_countdown = 0;
  int items_sent    = 0;

  period_weighted_mean_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .price        (price),
    .volume       (volume),
    .history_index(history_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .bar_mean     (bar_mean),
    .used_close   (used_close),
    .entry_valid  (entry_valid)
  );

  pwm_bar_checker bar_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .price          (price),
    .volume         (volume),
    .history_index  (history_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .bar_mean       (bar_mean),
    .used_close     (used_close),
    .entry_valid    (entry_valid),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: random ready bursts, one long hold-off on request, none at the tail.
  initial begin : result_flow
    wait (!rst);
    forever begin
      if (hold_output && !hold_served) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_served = 1'b1;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        @(negedge clk);
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 40)) @(negedge clk);
      end
    end
  end

  function automatic logic [PRICE_W-1:0] random_price();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [VOL_W-1:0] random_volume();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return VOL_W'(1);
      4:       return VOL_W'($urandom_range(0, 15));
      default: return VOL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offers one input transaction and returns once it has been accepted.
  task automatic send_item(input action_t act, input logic [PRICE_W-1:0] p,
                           input logic [VOL_W-1:0] v, input logic [IDX_W-1:0] idx);
    if (idling_on && gap_countdown == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 16)) @(negedge clk);
      gap_countdown = $urandom_range(0, 40);
    end else if (gap_countdown > 0) begin
      gap_countdown--;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    action        <= act;
    price         <= p;
    volume        <= v;
    history_index <= idx;
    do @(posedge clk); while (!in_ready);
    if (act != ACT_UNUSED) begin
      items_sent++;
    end
  endtask

  // Stops offering until every predicted result has come back.
  task automatic park_sender();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int  pick;
    int  n;
    bit  parked;
    parked = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty history, zero-weight closes, field extremes, spare code, reads.
    send_item(ACT_READ, '1, '1, 6'd0);
    send_item(ACT_CLOSE, 32'hFFFF_FFFF, 16'd0, '0);
    send_item(ACT_CLOSE, 32'd0, 16'hFFFF, '1);
    send_item(ACT_TICK, 32'hFFFF_FFFF, 16'hFFFF, '0);
    send_item(ACT_TICK, 32'd0, 16'hFFFF, '1);
    send_item(ACT_TICK, 32'h0000_0180, 16'd0, '0);
    send_item(ACT_TICK, 32'h1234_5678, 16'd1, '0);
    send_item(ACT_CLOSE, 32'hAAAA_5555, 16'h5555, 6'h2A);
    // A bar made only of zero-volume ticks still closes on the given price.
    send_item(ACT_TICK, 32'h8000_0001, 16'd0, '0);
    send_item(ACT_CLOSE, 32'h5555_AAAA, 16'hAAAA, 6'h15);
    // Nonzero weight with zero price gives a zero mean, not the close price.
    send_item(ACT_TICK, 32'd0, 16'd1, '0);
    send_item(ACT_CLOSE, '1, 16'd7, '0);
    send_item(ACT_UNUSED, '1, '1, '1);
    for (int i = 0; i < 6; i++) begin
      send_item(ACT_READ, '0, '0, IDX_W'(i));
    end
    send_item(ACT_READ, '0, '0, '1);
    park_sender();

    // A short bar of full-scale ticks gives the largest mean that still fits.
    idling_on = 1'b0;
    repeat (FULL_TICKS) send_item(ACT_TICK, '1, '1, '0);
    send_item(ACT_CLOSE, '0, '0, '0);
    send_item(ACT_READ, '0, '0, '0);
    idling_on = 1'b1;
    park_sender();

    // Random part: mostly whole bars with random ticks, plus reads and noise.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (!hold_output && items_sent >= HOLD_AT) begin
        // Keep offering closes and reads while results are held back.
        hold_output = 1'b1;
        repeat (HOLD_BURST) begin
          send_item($urandom_range(0, 1) ? ACT_READ : ACT_CLOSE, random_price(),
                    random_volume(), IDX_W'($urandom_range(0, HISTORY_DEPTH - 1)));
        end
      end
      if (!parked && items_sent >= PARK_AT) begin
        park_sender();
        parked = 1'b1;
      end
      if (items_sent >= QUIET_AFTER) begin
        idling_on = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
        repeat (n) begin
          // Now and then a read breaks into the middle of a bar.
          if ($urandom_range(0, 19) == 0) begin
            send_item(ACT_READ, random_price(), random_volume(),
                      IDX_W'($urandom_range(0, HISTORY_DEPTH - 1)));
          end
          send_item(ACT_TICK, random_price(), random_volume(), IDX_W'($urandom()));
        end
        send_item(ACT_CLOSE, random_price(), random_volume(), IDX_W'($urandom()));
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 3)) begin
          send_item(ACT_READ, random_price(), random_volume(),
                    IDX_W'($urandom_range(0, HISTORY_DEPTH - 1)));
        end
      end else begin
        send_item(ACT_UNUSED, random_price(), random_volume(), IDX_W'($urandom()));
      end
    end

    // Let everything drain, then give stray results time to show up.
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/pwm_pkg.sv
rtl/core/pwm_front.sv
rtl/core/pwm_queue.sv
rtl/core/pwm_div.sv
rtl/core/pwm_back.sv
rtl/core/period_weighted_mean_unit.sv
bench/pwm_bar_checker.sv
bench/period_weighted_mean_unit_test.sv
